### hdl/flr_pkg.sv
package flr_pkg;

  localparam int MAX_LABELS = 1024;
  localparam int RAW_W = 32;
  localparam int KEY_W = RAW_W - 1;
  localparam int DENSE_W = 11;
  localparam int CNT_W = $clog2(MAX_LABELS + 1);
  localparam int ADDR_W = (MAX_LABELS > 1) ? $clog2(MAX_LABELS) : 1;

  typedef enum logic [2:0] {
    RES_NONE,
    RES_ZERO,
    RES_HIT,
    RES_NEW,
    RES_OVF
  } res_kind_t;

  typedef struct packed {
    logic      load;
    logic      scan;
    res_kind_t finish;
  } flr_cmd_t;

  typedef struct packed {
    logic positive;
    logic hit;
    logic exhausted;
    logic full;
  } flr_status_t;

endpackage

### hdl/flr_ctrl.sv
module flr_ctrl
  import flr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  flr_status_t status,
  output flr_cmd_t    cmd,
  output logic        busy
);

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_t;

  state_t state;

  always_comb begin
    cmd = '{load: 1'b0, scan: 1'b0, finish: RES_NONE};
    unique case (state)
      ST_IDLE: begin
        cmd.load = start;
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        priority if (!status.positive) begin
          cmd.finish = RES_ZERO;
        end else if (status.hit) begin
          cmd.finish = RES_HIT;
        end else if (status.exhausted) begin
          cmd.finish = status.full ? RES_OVF : RES_NEW;
        end else begin
          cmd.finish = RES_NONE;
        end
      end
      default: begin
        cmd = '{load: 1'b0, scan: 1'b0, finish: RES_NONE};
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      busy  <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            state <= ST_SCAN;
            busy  <= 1'b1;
          end
        end
        ST_SCAN: begin
          if (cmd.finish != RES_NONE) begin
            state <= ST_IDLE;
            busy  <= 1'b0;
          end
        end
        default: begin
          state <= ST_IDLE;
          busy  <= 1'b0;
        end
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) (start && !busy) |=> busy)
    else $error("Accepted transaction did not raise busy.");

  assert property (@(posedge clk) disable iff (rst) busy |-> (state == ST_SCAN))
    else $error("Busy disagrees with controller state.");

  assert property (@(posedge clk) disable iff (rst)
    (cmd.finish != RES_NONE) |=> !busy)
    else $error("Busy did not drop after a finished transaction.");

endmodule

### hdl/flr_datapath.sv
module flr_datapath
  import flr_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  flr_cmd_t           cmd,
  input  logic [RAW_W-1:0]   raw_label,
  input  logic               image_start,
  output flr_status_t        status,
  output logic               done,
  output logic [DENSE_W-1:0] dense_label,
  output logic               table_overflow
);

  logic [KEY_W-1:0]  seen_labels [MAX_LABELS];
  logic [KEY_W-1:0]  key;
  logic              positive;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_inc;
  logic [CNT_W-1:0]  idx;
  logic              cmp_valid;
  logic [ADDR_W-1:0] cmp_idx;
  logic [KEY_W-1:0]  rdata;
  logic              issue;

  assign issue     = cmd.scan && (idx < count);
  assign count_inc = count + CNT_W'(1);

  assign status.positive  = positive;
  assign status.hit       = cmp_valid && (rdata == key);
  assign status.exhausted = !cmp_valid && (idx >= count);
  assign status.full      = (count == CNT_W'(MAX_LABELS));

  always_ff @(posedge clk) begin
    if (issue) begin
      rdata <= seen_labels[idx[ADDR_W-1:0]];
    end
    if (cmd.finish == RES_NEW) begin
      seen_labels[count[ADDR_W-1:0]] <= key;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key      <= raw_label[KEY_W-1:0];
      positive <= !raw_label[RAW_W-1] && (raw_label != '0);
    end
    if (issue) begin
      cmp_idx <= idx[ADDR_W-1:0];
    end
    unique case (cmd.finish)
      RES_HIT: begin
        dense_label    <= DENSE_W'(CNT_W'(cmp_idx) + CNT_W'(1));
        table_overflow <= 1'b0;
      end
      RES_NEW: begin
        dense_label    <= DENSE_W'(count_inc);
        table_overflow <= 1'b0;
      end
      RES_OVF: begin
        dense_label    <= '0;
        table_overflow <= 1'b1;
      end
      RES_ZERO: begin
        dense_label    <= '0;
        table_overflow <= 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      idx       <= '0;
      cmp_valid <= 1'b0;
      done      <= 1'b0;
    end else begin
      done <= (cmd.finish != RES_NONE);
      if (cmd.load) begin
        idx       <= '0;
        cmp_valid <= 1'b0;
        if (image_start) begin
          count <= '0;
        end
      end else begin
        cmp_valid <= issue;
        if (issue) begin
          idx <= idx + CNT_W'(1);
        end
        if (cmd.finish == RES_NEW) begin
          count <= count_inc;
        end
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) count <= CNT_W'(MAX_LABELS))
    else $error("Label count exceeds table size.");

  assert property (@(posedge clk) disable iff (rst)
    status.hit |-> (CNT_W'(cmp_idx) < count))
    else $error("Match reported beyond the filled part of the table.");

  assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && $past(cmd.finish == RES_NEW)) |-> (count == $past(count_inc)))
    else $error("Insert did not advance the label count.");

endmodule

### hdl/first_seen_label_relabeler.sv
// A non-positive label or a new label in an empty table is decided on entering scan;
// a label in slot k when slot k is compared, another new label when all used slots are.
// Throughput: one transaction at a time; the table is searched one entry per cycle
// through a single registered read port, and start is taken again in the result cycle.
// The result is shown for one cycle under done, since the receiver cannot stall.
// Synchronous reset empties the table count; table contents are not cleared.
module first_seen_label_relabeler
  import flr_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [RAW_W-1:0]   raw_label,
  input  logic               image_start,
  output logic               done,
  output logic [DENSE_W-1:0] dense_label,
  output logic               table_overflow
);

  flr_cmd_t    cmd;
  flr_status_t status;

  flr_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  flr_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .raw_label      (raw_label),
    .image_start    (image_start),
    .status         (status),
    .done           (done),
    .dense_label    (dense_label),
    .table_overflow (table_overflow)
  );

endmodule

### dv/tb_first_seen_label_relabeler.sv
module tb_first_seen_label_relabeler;
  timeunit 1ns;
  timeprecision 1ps;

  import flr_pkg::*;

  localparam int RESET_CYCLES = 12;
  localparam int SETTLE_CYCLES = MAX_LABELS + 8;
  localparam int NUM_DIRECTED = 18;
  localparam int PHASE_PIXELS = 60;

  typedef struct packed {
    logic [DENSE_W-1:0] dense;
    logic               ovf;
  } pixel_result_t;

  typedef struct packed {
    logic [RAW_W-1:0]   raw;
    logic               sof;
    logic               typed;
    logic [DENSE_W-1:0] dense;
    logic               ovf;
  } directed_row_t;

  directed_row_t directed_rows [NUM_DIRECTED] = '{
    '{32'h0000_0001, 1'b1, 1'b1, 11'd1, 1'b0},
    '{32'h0000_0000, 1'b0, 1'b1, 11'd0, 1'b0},
    '{32'h8000_0000, 1'b0, 1'b1, 11'd0, 1'b0},
    '{32'hFFFF_FFFF, 1'b0, 1'b1, 11'd0, 1'b0},
    '{32'h7FFF_FFFF, 1'b0, 1'b1, 11'd2, 1'b0},
    '{32'h0000_0001, 1'b0, 1'b1, 11'd1, 1'b0},
    '{32'h7FFF_FFFF, 1'b0, 1'b0, 11'd0, 1'b0},
    '{32'h5555_5555, 1'b0, 1'b0, 11'd0, 1'b0},
    '{32'h2AAA_AAAA, 1'b0, 1'b0, 11'd0, 1'b0},
    '{32'h8000_0001, 1'b0, 1'b1, 11'd0, 1'b0},
    '{32'h0000_0000, 1'b1, 1'b1, 11'd0, 1'b0},
    '{32'h7FFF_FFFF, 1'b0, 1'b1, 11'd1, 1'b0},
    '{32'h7FFF_FFFF, 1'b1, 1'b1, 11'd1, 1'b0},
    '{32'h4000_0000, 1'b0, 1'b0, 11'd0, 1'b0},
    '{32'h0000_0001, 1'b0, 1'b0, 11'd0, 1'b0},
    '{32'h0000_0001, 1'b1, 1'b1, 11'd1, 1'b0},
    '{32'hC000_0000, 1'b0, 1'b1, 11'd0, 1'b0},
    '{32'h0000_0002, 1'b0, 1'b0, 11'd0, 1'b0}
  };

  logic               clk = 1'b0;
  logic               rst;
  logic               start;
  logic               busy;
  logic [RAW_W-1:0]   raw_label;
  logic               image_start;
  logic               done;
  logic [DENSE_W-1:0] dense_label;
  logic               table_overflow;

  logic [KEY_W-1:0] known_keys [MAX_LABELS];
  int               known_count = 0;
  pixel_result_t    pending_results [$];
  int               mismatches = 0;
  int               sender_idle_pct = 0;
  int               pixels_sent = 0;

  first_seen_label_relabeler u_dut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .raw_label      (raw_label),
    .image_start    (image_start),
    .done           (done),
    .dense_label    (dense_label),
    .table_overflow (table_overflow)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic pixel_result_t relabel_pixel(logic [RAW_W-1:0] raw, logic sof);
    pixel_result_t res;
    int slot;
    res = '0;
    slot = -1;
    if (sof) begin
      known_count = 0;
    end
    if (raw != '0 && !raw[RAW_W-1]) begin
      for (int k = 0; k < known_count; k++) begin
        if (slot < 0 && known_keys[k] == raw[KEY_W-1:0]) begin
          slot = k;
        end
      end
      if (slot >= 0) begin
        res.dense = DENSE_W'(slot + 1);
      end else if (known_count < MAX_LABELS) begin
        known_keys[known_count] = raw[KEY_W-1:0];
        known_count++;
        res.dense = DENSE_W'(known_count);
      end else begin
        res.ovf = 1'b1;
      end
    end
    return res;
  endfunction

  function automatic logic [KEY_W-1:0] random_key();
    logic [KEY_W-1:0] key;
    case ($urandom_range(15))
      0: key = KEY_W'(1);
      1: key = '1;
      default: key = KEY_W'($urandom);
    endcase
    if (key == '0) begin
      key = KEY_W'(1);
    end
    return key;
  endfunction

  function automatic logic [RAW_W-1:0] random_nonpositive();
    logic [RAW_W-1:0] raw;
    case ($urandom_range(3))
      0: raw = '0;
      1: raw = 32'h8000_0000;
      2: raw = '1;
      default: raw = {1'b1, KEY_W'($urandom)};
    endcase
    return raw;
  endfunction

  function automatic logic [KEY_W-1:0] fill_key(logic [KEY_W-1:0] mult, int idx);
    logic [KEY_W-1:0] key;
    key = mult * KEY_W'(idx + 1);
    return key;
  endfunction

  function void report_mismatch(string what);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%s", what);
    end
  endfunction

  task automatic send_pixel(input logic [RAW_W-1:0] raw, input logic sof,
                            input logic typed, input pixel_result_t typed_res);
    pixel_result_t predicted;
    while (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start       <= 1'b1;
    raw_label   <= raw;
    image_start <= sof;
    @(posedge clk);
    while (busy) begin
      @(posedge clk);
    end
    predicted = relabel_pixel(raw, sof);
    pending_results = {pending_results, (typed ? typed_res : predicted)};
    pixels_sent++;
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic run_image(input int length, input int pool_size);
    logic [KEY_W-1:0] pool [$];
    logic [RAW_W-1:0] raw;
    logic             sof;
    int               roll;
    for (int p = 0; p < pool_size; p++) begin
      pool = {pool, random_key()};
    end
    for (int i = 0; i < length; i++) begin
      if ($urandom_range(99) < 3) begin
        wait_drained();
      end
      sof = (i == 0 && $urandom_range(9) != 0) || $urandom_range(99) < 3;
      roll = $urandom_range(99);
      if (roll < 10) begin
        raw = random_nonpositive();
      end else if (roll < 15) begin
        raw = $urandom;
      end else begin
        raw = {1'b0, pool[$urandom_range(pool_size - 1)]};
      end
      send_pixel(raw, sof, 1'b0, '0);
    end
  endtask

  task automatic fill_table();
    logic [KEY_W-1:0] mult;
    logic [RAW_W-1:0] raw;
    logic             first;
    int               next_new;
    int               roll;
    mult = KEY_W'($urandom) | KEY_W'(1);
    next_new = 0;
    first = 1'b1;
    while (next_new < MAX_LABELS + 16) begin
      roll = $urandom_range(99);
      if (roll < 6 && next_new > 0) begin
        raw = {1'b0, fill_key(mult, $urandom_range(next_new - 1))};
      end else if (roll < 10) begin
        raw = random_nonpositive();
      end else begin
        raw = {1'b0, fill_key(mult, next_new)};
        next_new++;
      end
      send_pixel(raw, first, 1'b0, '0);
      first = 1'b0;
    end
    for (int i = 0; i < 24; i++) begin
      roll = $urandom_range(99);
      if (roll < 40) begin
        raw = {1'b0, fill_key(mult, $urandom_range(next_new - 1, MAX_LABELS))};
      end else if (roll < 70) begin
        raw = {1'b0, fill_key(mult, $urandom_range(MAX_LABELS - 1))};
      end else if (roll < 85) begin
        raw = {1'b0, fill_key(mult, next_new)};
        next_new++;
      end else begin
        raw = random_nonpositive();
      end
      send_pixel(raw, 1'b0, 1'b0, '0);
    end
  endtask

  always @(posedge clk) begin : check_result
    pixel_result_t want;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf(
          "result with no pending transaction: dense_label %0d table_overflow %0d",
          dense_label, table_overflow));
      end else begin
        want = pending_results.pop_front();
        if (dense_label !== want.dense || table_overflow !== want.ovf) begin
          report_mismatch($sformatf(
            "mismatch: expected dense_label %0d table_overflow %0d, got %0d %0d",
            want.dense, want.ovf, dense_label, table_overflow));
        end
      end
    end
  end

  initial begin
    #10_000_000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin : stimulus
    int idle_pct [3];
    int phase_begin;
    pixel_result_t typed_res;
    idle_pct = '{0, 77, 13};
    rst         <= 1'b1;
    start       <= 1'b0;
    raw_label   <= '0;
    image_start <= 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    for (int r = 0; r < NUM_DIRECTED; r++) begin
      typed_res.dense = directed_rows[r].dense;
      typed_res.ovf   = directed_rows[r].ovf;
      send_pixel(directed_rows[r].raw, directed_rows[r].sof, directed_rows[r].typed,
                 typed_res);
    end
    wait_drained();

    for (int ph = 0; ph < 3; ph++) begin
      sender_idle_pct = idle_pct[ph];
      phase_begin = pixels_sent;
      while (pixels_sent - phase_begin < PHASE_PIXELS) begin
        if ($urandom_range(4) == 0) begin
          run_image($urandom_range(4, 24), $urandom_range(20, 60));
        end else begin
          run_image($urandom_range(4, 24), $urandom_range(1, 10));
        end
      end
      if (ph == 2) begin
        fill_table();
      end
      wait_drained();
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
